[rtl/ate_pkg.sv]
// ----------------------------------------------------------------------------
// ate_pkg: shared types for the trap instruction emulator
// Result kinds, the decoded item that crosses the queue, and the
// configuration bundle handed to the back end.
// ----------------------------------------------------------------------------
package ate_pkg;

    typedef enum logic [1:0] {
        KIND_BRANCH_LINK = 2'd0,
        KIND_BRANCH      = 2'd1,
        KIND_COND_SET    = 2'd2,
        KIND_UNHANDLED   = 2'd3
    } kind_t;

    localparam int LIMIT_W = 21;
    localparam int COUNT_W = 32;
    localparam int INDEX_W = 20;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hffff_ffff;

    // decoded item: everything the back end needs apart from the counter
    typedef struct packed {
        kind_t       kind;
        logic [63:0] next_pc;
        logic        link_write;
        logic [63:0] link_value;
        logic        dest_write;
        logic [4:0]  dest_index;
        logic        dest_value;
        logic [63:0] trap_pc;
        logic [63:0] trace_data;
    } dec_t;

    typedef struct packed {
        logic               clear;
        logic [LIMIT_W-1:0] limit;
    } cfg_t;

endpackage

[rtl/arm64_trap_instruction_emulator.sv]
// ----------------------------------------------------------------------------
// arm64_trap_instruction_emulator: trapped branch and conditional set emulator
// Takes one trapped instruction per item on the s_ stream and returns one
// result per item on the m_ stream: resume address, link and general
// register writes, an optional trace record and the handled event count.
//
// Path: an accepted item is written into the decode queue and then, once
// the back end takes it, into the result register.
// Throughput: one item per cycle while m_tready stays high, set by the
// combinational decode and the single counter update in the back end.
// Reset: aresetn clears the queue, the result valid flag, the event count
// and trace_limit. No clearing pass is needed.
// Stall: when m_tready is low the result holds; the queue keeps taking items
// until its QUEUE_DEPTH entries are full, then s_tready drops.
// Configuration: the APB port holds trace_limit at byte address 0; a write
// clamps it to 2^20 and clears the event count.
// ----------------------------------------------------------------------------
module arm64_trap_instruction_emulator #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    // trap_pc[63:0], instruction_word[95:64], source_value[159:96],
    // flags_nzcv[163:160], zero fill [167:164]
    input  logic [167:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // next_pc[63:0], link_write[64], link_value[128:65], dest_write[129],
    // dest_index[134:130], dest_value[135], record_valid[136],
    // record_index[156:137], record_addr[220:157], record_data[284:221],
    // events_seen[316:285], zero fill [319:317]
    output logic [319:0] m_tdata,
    // kind[1:0]
    output logic [1:0]   m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic                          REG_TRACE_LIMIT = 1'b0;
    localparam logic [ate_pkg::LIMIT_W-1:0]   LIMIT_MAX       = 21'h10_0000;

    logic [ate_pkg::LIMIT_W-1:0]   limit_reg, limit_next;
    logic                          cfg_write;
    ate_pkg::cfg_t                 cfg;
    ate_pkg::dec_t                 dec;
    ate_pkg::dec_t                 q_item;
    ate_pkg::dec_t                 res;
    logic                          q_valid;
    logic                          q_ready;
    logic                          rec_valid;
    logic [ate_pkg::INDEX_W-1:0]   rec_index;
    logic [ate_pkg::COUNT_W-1:0]   seen;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready & (paddr[2] == REG_TRACE_LIMIT);

    always_comb begin
        limit_next = limit_reg;
        if (cfg_write) begin
            limit_next = (pwdata[20:0] > LIMIT_MAX) ? LIMIT_MAX : pwdata[20:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '0;
        end else begin
            limit_reg <= limit_next;
        end
    end

    assign prdata    = (paddr[2] == REG_TRACE_LIMIT) ? {11'd0, limit_reg} : 32'd0;
    assign cfg.clear = cfg_write;
    assign cfg.limit = limit_reg;

    ate_front u_front (
        .trap_pc          (s_tdata[63:0]),
        .instruction_word (s_tdata[95:64]),
        .source_value     (s_tdata[159:96]),
        .flags_nzcv       (s_tdata[163:160]),
        .dec              (dec)
    );

    ate_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_item  (dec),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    ate_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .pop_valid    (q_valid),
        .pop_ready    (q_ready),
        .pop_item     (q_item),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_item     (res),
        .record_valid (rec_valid),
        .record_index (rec_index),
        .events_seen  (seen)
    );

    assign m_tuser = res.kind;
    assign m_tdata = {3'd0, seen, res.trace_data, res.trap_pc, rec_index, rec_valid,
                      res.dest_value, res.dest_index, res.dest_write,
                      res.link_value, res.link_write, res.next_pc};

endmodule

[rtl/ate_front.sv]
// ----------------------------------------------------------------------------
// ate_front: instruction classifier
// Matches the trapped word against the three handled encodings, evaluates
// the condition of a conditional set and forms the resume and link addresses.
// ----------------------------------------------------------------------------
module ate_front (
    input  logic [63:0]   trap_pc,
    input  logic [31:0]   instruction_word,
    input  logic [63:0]   source_value,
    input  logic [3:0]    flags_nzcv,
    output ate_pkg::dec_t dec
);

    localparam logic [31:0] BR_MASK    = 32'hffff_fc00;
    localparam logic [31:0] BLR_MATCH  = 32'hd73f_0800;
    localparam logic [31:0] BR_MATCH   = 32'hd71f_0800;
    localparam logic [31:0] CSET_MASK  = 32'hffff_07e0;
    localparam logic [31:0] CSET_MATCH = 32'h1a9f_07e0;
    localparam logic [4:0]  ZERO_REG   = 5'h1f;

    // outcome is 1 when the encoded condition fails; always codes give 0
    function automatic logic cond_outcome(input logic [3:0] cond, input logic [3:0] nzcv);
        logic n;
        logic z;
        logic c;
        logic v;
        logic holds;
        logic res;
        n = nzcv[3];
        z = nzcv[2];
        c = nzcv[1];
        v = nzcv[0];
        holds = 1'b0;
        res = 1'b0;
        case (cond[3:1])
            3'd0: holds = z;
            3'd1: holds = c;
            3'd2: holds = n;
            3'd3: holds = v;
            3'd4: holds = c & ~z;
            3'd5: holds = (n == v);
            3'd6: holds = (n == v) & ~z;
            default: holds = 1'b0;
        endcase
        if (cond[3:1] != 3'd7) begin
            res = ~(holds ^ cond[0]);
        end
        return res;
    endfunction

    logic [63:0] pc_plus4;
    logic        outcome;

    assign pc_plus4 = trap_pc + 64'd4;
    assign outcome  = cond_outcome(instruction_word[15:12], flags_nzcv);

    always_comb begin
        dec = '0;
        dec.kind = ate_pkg::KIND_UNHANDLED;
        if ((instruction_word & BR_MASK) == BLR_MATCH) begin
            dec.kind       = ate_pkg::KIND_BRANCH_LINK;
            dec.next_pc    = source_value;
            dec.link_write = 1'b1;
            dec.link_value = pc_plus4;
            dec.trap_pc    = trap_pc;
            dec.trace_data = source_value;
        end else if ((instruction_word & BR_MASK) == BR_MATCH) begin
            dec.kind       = ate_pkg::KIND_BRANCH;
            dec.next_pc    = source_value;
            dec.trap_pc    = trap_pc;
            dec.trace_data = source_value;
        end else if ((instruction_word & CSET_MASK) == CSET_MATCH) begin
            dec.kind       = ate_pkg::KIND_COND_SET;
            dec.next_pc    = pc_plus4;
            dec.dest_value = outcome;
            dec.trap_pc    = trap_pc;
            dec.trace_data = {63'd0, outcome};
            // drop writes to the zero register
            if (instruction_word[4:0] != ZERO_REG) begin
                dec.dest_write = 1'b1;
                dec.dest_index = instruction_word[4:0];
            end
        end
    end

endmodule

[rtl/ate_queue.sv]
// ----------------------------------------------------------------------------
// ate_queue: decoded item queue
// Small circular buffer between the classifier and the back end so that
// each side stalls on its own.
// ----------------------------------------------------------------------------
module ate_queue #(
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  ate_pkg::dec_t push_item,
    output logic          pop_valid,
    input  logic          pop_ready,
    output ate_pkg::dec_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ate_pkg::dec_t    store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid & push_ready;
    assign pop        = pop_valid & pop_ready;
    assign pop_item   = store_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/ate_back.sv]
// ----------------------------------------------------------------------------
// ate_back: event counter and result register
// Counts handled events, gates trace records on the limit and holds the
// result until the receiver takes it.
// ----------------------------------------------------------------------------
module ate_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ate_pkg::cfg_t                   cfg,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  ate_pkg::dec_t                   pop_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ate_pkg::dec_t                   out_item,
    output logic                            record_valid,
    output logic [ate_pkg::INDEX_W-1:0]     record_index,
    output logic [ate_pkg::COUNT_W-1:0]     events_seen
);

    logic                          out_valid_reg, out_valid_next;
    ate_pkg::dec_t                 item_reg;
    ate_pkg::dec_t                 item_next;
    logic                          rec_valid_reg;
    logic [ate_pkg::INDEX_W-1:0]   rec_index_reg;
    logic [ate_pkg::COUNT_W-1:0]   seen_reg;
    logic [ate_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic                          load;
    logic                          handled;
    logic                          rec_hit;

    assign pop_ready = !out_valid_reg || out_ready;
    assign load      = pop_valid & pop_ready;
    assign handled   = (pop_item.kind != ate_pkg::KIND_UNHANDLED);
    assign rec_hit   = handled && (count_reg < ate_pkg::COUNT_W'(cfg.limit));

    always_comb begin
        count_next = count_reg;
        if (cfg.clear) begin
            count_next = '0;
        end else if (load && handled && count_reg != ate_pkg::COUNT_MAX) begin
            count_next = count_reg + 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
        // clear record fields that carry no meaning
        item_next = pop_item;
        if (!rec_hit) begin
            item_next.trap_pc    = '0;
            item_next.trace_data = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg      <= item_next;
            rec_valid_reg <= rec_hit;
            rec_index_reg <= rec_hit ? count_reg[ate_pkg::INDEX_W-1:0] : '0;
            seen_reg      <= count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_item     = item_reg;
    assign record_valid = rec_valid_reg;
    assign record_index = rec_index_reg;
    assign events_seen  = seen_reg;

    a_unhandled_no_record: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && item_reg.kind == ate_pkg::KIND_UNHANDLED |-> !rec_valid_reg)
        else $error("record emitted for an unhandled instruction");

    a_record_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && rec_valid_reg |->
        seen_reg == ate_pkg::COUNT_W'(rec_index_reg) + 32'd1)
        else $error("record slot out of step with event count");

    a_count_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        load && handled && !cfg.clear && count_reg != ate_pkg::COUNT_MAX |=>
        count_reg == $past(count_reg) + 32'd1)
        else $error("event count did not advance");

    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg.clear |=> count_reg == '0)
        else $error("limit write did not clear the count");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: trapped branch and conditional set emulator
// Streams trapped instructions through the block with random gaps and
// back-pressure, predicts every result in the bench, and compares each
// returned item field by field. The trace limit is changed between phases
// while the block is idle, covering zero, small limits and the clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam logic [31:0] MASK_BRANCH    = 32'hfffffc00;
    localparam logic [31:0] OP_BRANCH_LINK = 32'hd73f0800;
    localparam logic [31:0] OP_BRANCH      = 32'hd71f0800;
    localparam logic [31:0] MASK_COND_SET  = 32'hffff07e0;
    localparam logic [31:0] OP_COND_SET    = 32'h1a9f07e0;
    localparam logic [4:0]  REG_ZERO       = 5'd31;
    localparam logic [20:0] LIMIT_SLOTS    = 21'd1048576;
    localparam logic [20:0] LIMIT_ALL_ONES = 21'h1fffff;
    localparam logic [2:0]  ADDR_TRACE_LIMIT = 3'd0;
    localparam int          CYCLE_LIMIT    = 400000;

    typedef enum int {
        PICK_BRANCH_LINK,
        PICK_BRANCH,
        PICK_COND_SET,
        PICK_NEAR_MISS,
        PICK_NOISE
    } pick_t;

    typedef struct {
        logic [63:0] pc;
        logic [31:0] word;
        logic [63:0] src;
        logic [3:0]  nzcv;
    } trap_t;

    typedef struct {
        ate_pkg::kind_t kind;
        logic [63:0] next_pc;
        logic        link_write;
        logic [63:0] link_value;
        logic        dest_write;
        logic [4:0]  dest_index;
        logic        dest_value;
        logic        record_valid;
        logic [19:0] record_index;
        logic [63:0] record_addr;
        logic [63:0] record_data;
        logic [31:0] events_seen;
    } outcome_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [167:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [319:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    // bench copy of the block's state
    logic [20:0]  model_limit = '0;
    logic [31:0]  model_events = '0;

    outcome_t     pending_outcomes[$];
    int           fail_count = 0;
    int           cycle_count = 0;
    bit           no_idle = 1'b0;

    arm64_trap_instruction_emulator i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Inverted condition: outcome is 1 when the encoded condition fails.
    function automatic logic cond_set_value(input logic [3:0] cond, input logic [3:0] nzcv);
        logic n, z, c, v, holds;
        n = nzcv[3];
        z = nzcv[2];
        c = nzcv[1];
        v = nzcv[0];
        case (cond[3:1])
            3'd0: holds = z;
            3'd1: holds = c;
            3'd2: holds = n;
            3'd3: holds = v;
            3'd4: holds = c & ~z;
            3'd5: holds = (n == v);
            3'd6: holds = (n == v) && !z;
            default: return 1'b0;
        endcase
        if (cond[0]) holds = ~holds;
        return ~holds;
    endfunction

    // Work out the result of one trapped instruction and advance the count.
    function automatic outcome_t emulate_trap(input trap_t t);
        outcome_t    r;
        logic        handled;
        logic [63:0] data;
        r = '{kind: ate_pkg::KIND_UNHANDLED, default: '0};
        handled = 1'b1;
        data = '0;
        if ((t.word & MASK_BRANCH) == OP_BRANCH_LINK) begin
            r.kind = ate_pkg::KIND_BRANCH_LINK;
            r.next_pc = t.src;
            r.link_write = 1'b1;
            r.link_value = t.pc + 64'd4;
            data = t.src;
        end else if ((t.word & MASK_BRANCH) == OP_BRANCH) begin
            r.kind = ate_pkg::KIND_BRANCH;
            r.next_pc = t.src;
            data = t.src;
        end else if ((t.word & MASK_COND_SET) == OP_COND_SET) begin
            r.kind = ate_pkg::KIND_COND_SET;
            r.next_pc = t.pc + 64'd4;
            if (t.word[4:0] != REG_ZERO) begin
                r.dest_write = 1'b1;
                r.dest_index = t.word[4:0];
            end
            r.dest_value = cond_set_value(t.word[15:12], t.nzcv);
            data = {63'd0, r.dest_value};
        end else begin
            handled = 1'b0;
        end
        if (handled) begin
            if (model_events < {11'd0, model_limit}) begin
                r.record_valid = 1'b1;
                r.record_index = model_events[19:0];
                r.record_addr = t.pc;
                r.record_data = data;
            end
            if (model_events != ate_pkg::COUNT_MAX) model_events = model_events + 32'd1;
        end
        r.events_seen = model_events;
        return r;
    endfunction

    function automatic outcome_t unpack_result(input logic [319:0] d, input logic [1:0] u);
        outcome_t r;
        r.kind = ate_pkg::kind_t'(u);
        r.next_pc = d[63:0];
        r.link_write = d[64];
        r.link_value = d[128:65];
        r.dest_write = d[129];
        r.dest_index = d[134:130];
        r.dest_value = d[135];
        r.record_valid = d[136];
        r.record_index = d[156:137];
        r.record_addr = d[220:157];
        r.record_data = d[284:221];
        r.events_seen = d[316:285];
        return r;
    endfunction

    function automatic trap_t make_trap(input logic [63:0] pc, input logic [31:0] word,
                                        input logic [63:0] src, input logic [3:0] nzcv);
        trap_t t;
        t.pc = pc;
        t.word = word;
        t.src = src;
        t.nzcv = nzcv;
        return t;
    endfunction

    function automatic logic [63:0] random_dword();
        logic [63:0] d;
        case ($urandom_range(0, 7))
            0: d = '1;
            1: d = 64'hffff_ffff_ffff_fffc - 64'($urandom_range(0, 3));
            2: d = 64'($urandom_range(0, 15));
            default: d = {$urandom, $urandom};
        endcase
        return d;
    endfunction

    // Mostly well-formed instructions, with near misses and noise mixed in.
    function automatic trap_t random_trap();
        trap_t       t;
        pick_t       pick;
        logic [31:0] base, mask;
        int          bit_pos;
        case ($urandom_range(0, 9))
            0, 1:    pick = PICK_BRANCH_LINK;
            2, 3:    pick = PICK_BRANCH;
            4, 5, 6: pick = PICK_COND_SET;
            7:       pick = PICK_NEAR_MISS;
            default: pick = PICK_NOISE;
        endcase
        t.pc = random_dword();
        t.src = random_dword();
        t.nzcv = 4'($urandom_range(0, 15));
        case (pick)
            PICK_BRANCH_LINK: t.word = OP_BRANCH_LINK | ($urandom & ~MASK_BRANCH);
            PICK_BRANCH:      t.word = OP_BRANCH | ($urandom & ~MASK_BRANCH);
            PICK_COND_SET:    t.word = OP_COND_SET | ($urandom & ~MASK_COND_SET);
            PICK_NEAR_MISS: begin
                case ($urandom_range(0, 2))
                    0: begin base = OP_BRANCH_LINK; mask = MASK_BRANCH; end
                    1: begin base = OP_BRANCH; mask = MASK_BRANCH; end
                    default: begin base = OP_COND_SET; mask = MASK_COND_SET; end
                endcase
                // flip one fixed bit of the pattern
                do bit_pos = $urandom_range(0, 31); while (!mask[bit_pos]);
                t.word = (base | ($urandom & ~mask)) ^ (32'd1 << bit_pos);
            end
            default: t.word = $urandom;
        endcase
        return t;
    endfunction

    task automatic send_trap(input trap_t t);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {4'd0, t.nzcv, t.src, t.word, t.pc};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_outcomes.push_back(emulate_trap(t));
    endtask

    // Hold off until every result is back and the pipeline has drained.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_trace_limit(input logic [20:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_TRACE_LIMIT;
        pwdata <= {11'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        model_limit = (value > LIMIT_SLOTS) ? LIMIT_SLOTS : value;
        model_events = '0;
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_trap(random_trap());
        end
        no_idle = 1'b0;
    endtask

    // Result sink: random stall before each item, sometimes none at all.
    initial begin : result_sink
        int stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_tready <= 1'b1;
            end
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge aclk) begin : result_check
        outcome_t got;
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = unpack_result(m_tdata, m_tuser);
            if (pending_outcomes.size() == 0) begin
                note_mismatch("unexpected item, next_pc", '0, got.next_pc);
            end else begin
                want = pending_outcomes.pop_front();
                if (got.kind != want.kind)
                    note_mismatch("kind", 64'(want.kind), 64'(got.kind));
                if (got.next_pc != want.next_pc)
                    note_mismatch("next_pc", want.next_pc, got.next_pc);
                if (got.link_write != want.link_write)
                    note_mismatch("link_write", 64'(want.link_write), 64'(got.link_write));
                if (got.link_value != want.link_value)
                    note_mismatch("link_value", want.link_value, got.link_value);
                if (got.dest_write != want.dest_write)
                    note_mismatch("dest_write", 64'(want.dest_write), 64'(got.dest_write));
                if (got.dest_index != want.dest_index)
                    note_mismatch("dest_index", 64'(want.dest_index), 64'(got.dest_index));
                if (got.dest_value != want.dest_value)
                    note_mismatch("dest_value", 64'(want.dest_value), 64'(got.dest_value));
                if (got.record_valid != want.record_valid)
                    note_mismatch("record_valid", 64'(want.record_valid),
                                  64'(got.record_valid));
                if (got.record_index != want.record_index)
                    note_mismatch("record_index", 64'(want.record_index),
                                  64'(got.record_index));
                if (got.record_addr != want.record_addr)
                    note_mismatch("record_addr", want.record_addr, got.record_addr);
                if (got.record_data != want.record_data)
                    note_mismatch("record_data", want.record_data, got.record_data);
                if (got.events_seen != want.events_seen)
                    note_mismatch("events_seen", 64'(want.events_seen),
                                  64'(got.events_seen));
            end
        end
    end

    // Reset limit of zero: events count, but nothing is traced.
    task automatic test_reset_limit();
        send_trap(make_trap(64'h0000_0000_0040_0000, OP_BRANCH_LINK | 32'h3a0,
                            64'h0000_0000_0040_1000, 4'h0));
        send_trap(make_trap(64'h0000_0000_0040_0004, 32'h0000_0000, 64'h1, 4'hf));
        quiesce();
    endtask

    // Extremes of the fields, every condition code, register thirty-one
    // and words that just miss a pattern; the small limit stops tracing early.
    task automatic test_directed();
        logic [4:0] wd;
        write_trace_limit(21'd4);
        send_trap(make_trap('1, OP_BRANCH_LINK | ~MASK_BRANCH, '0, 4'hf));
        send_trap(make_trap('0, OP_BRANCH, '1, 4'h0));
        for (int c = 0; c < 16; c++) begin
            case (c % 4)
                0: wd = 5'd0;
                1: wd = REG_ZERO;
                2: wd = 5'd30;
                default: wd = 5'($urandom_range(1, 29));
            endcase
            send_trap(make_trap('1 - 64'(c), OP_COND_SET | (32'(c) << 12) |
                                (32'(c % 2) << 11) | 32'(wd),
                                {$urandom, $urandom}, 4'(c * 7)));
        end
        send_trap(make_trap(64'h1234, 32'hffff_ffff, '1, 4'h5));
        send_trap(make_trap(64'h1238, 32'h0000_0000, '0, 4'ha));
        send_trap(make_trap(64'h123c, OP_BRANCH_LINK | 32'h400, 64'h77, 4'h0));
        send_trap(make_trap(64'h1240, OP_COND_SET & ~32'h20, 64'h88, 4'h0));
        quiesce();
    endtask

    // Limits above the buffer size act as the buffer size.
    task automatic test_limit_clamp();
        write_trace_limit(LIMIT_ALL_ONES);
        send_random(40);
        quiesce();
        write_trace_limit(LIMIT_SLOTS);
        send_random(40);
        quiesce();
    endtask

    task automatic test_random_phases();
        logic [20:0] limit;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: limit = 21'd0;
                1: limit = 21'd1;
                2: limit = 21'($urandom_range(0, 64));
                3: limit = LIMIT_ALL_ONES;
                4: limit = 21'($urandom);
                5: limit = LIMIT_SLOTS;
                6: limit = 21'($urandom_range(0, 200));
                default: limit = 21'($urandom_range(2, 40));
            endcase
            write_trace_limit(limit);
            send_random(95);
            quiesce();
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_limit();
        test_directed();
        test_limit_clamp();
        test_random_phases();
        quiesce();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
